>>> hdl/sic_pkg.sv
// Package for segment_intersection_classify: widths and result codes shared by the
// top level and its checker, and the pipeline payload type of the top level.
// Depends on nothing.
package sic_pkg;

  localparam int CW   = 24;          // coordinate width
  localparam int DW   = CW + 1;      // coordinate difference
  localparam int PW   = 2 * DW;      // product of two differences
  localparam int NW   = PW + 1;      // num, numcd, den
  localparam int MW   = NW - 1;      // magnitude of num or den
  localparam int HW   = (MW + 1) / 2; // low split of |num|
  localparam int RW   = MW + DW;     // |num| * |delta|
  localparam int QB   = CW + 1;      // quotient bits before overflow
  localparam int SW   = CW + 3;      // base plus quotient

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_COLLINEAR = 3'd0,
    KIND_PARALLEL  = 3'd1,
    KIND_SEG_CROSS = 3'd2,
    KIND_A_BIS_B   = 3'd3,
    KIND_B_BIS_A   = 3'd4,
    KIND_LINES     = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic                   dz;
    logic signed [CW-1:0]   base_x;
    logic signed [CW-1:0]   base_y;
    logic                   neg_x;
    logic                   neg_y;
    logic                   ovf_x;
    logic                   ovf_y;
    logic        [MW-1:0]   den_mag;
  } div_t;

endpackage

>>> hdl/segment_intersection_classify.sv
// Top level of segment_intersection_classify: the whole pipeline.
// Depends on sic_pkg.
//
// Usage: present segments AB and CD on in_a_x .. in_d_y with in_valid; a
// transfer happens on a clock edge with in_valid high and in_stall low.
// One result per item appears on out_kind, out_cross_x, out_cross_y,
// out_point_valid and out_point_saturated with out_valid; it transfers on
// an edge with out_valid high and out_stall low.
// The pipeline steps, in order: differences, products, cross terms,
// magnitudes, split multiply, product sum, overflow compare, then one
// restoring division stage per quotient bit, then the clamp into the output
// register. Throughput is one item per cycle while the output is not stalled.
// A stalled result holds the whole pipeline; in_stall is high while the
// output register holds a result the receiver stalls.
// Synchronous active-low reset clears all valid bits; data is not reset.
module segment_intersection_classify (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [sic_pkg::CW-1:0] in_a_x,
  input  logic signed [sic_pkg::CW-1:0] in_a_y,
  input  logic signed [sic_pkg::CW-1:0] in_b_x,
  input  logic signed [sic_pkg::CW-1:0] in_b_y,
  input  logic signed [sic_pkg::CW-1:0] in_c_x,
  input  logic signed [sic_pkg::CW-1:0] in_c_y,
  input  logic signed [sic_pkg::CW-1:0] in_d_x,
  input  logic signed [sic_pkg::CW-1:0] in_d_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_kind,
  output logic signed [sic_pkg::CW-1:0] out_cross_x,
  output logic signed [sic_pkg::CW-1:0] out_cross_y,
  output logic                          out_point_valid,
  output logic                          out_point_saturated
);

  localparam int CW = sic_pkg::CW;
  localparam int DW = sic_pkg::DW;
  localparam int PW = sic_pkg::PW;
  localparam int NW = sic_pkg::NW;
  localparam int MW = sic_pkg::MW;
  localparam int HW = sic_pkg::HW;
  localparam int RW = sic_pkg::RW;
  localparam int QB = sic_pkg::QB;
  localparam int SW = sic_pkg::SW;

  logic en;
  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  // stage 1: differences
  logic                 s1_v_r;
  logic signed [DW-1:0] acx_r, acy_r, cdx_r, cdy_r, abx_r, aby_r;
  logic signed [CW-1:0] s1_ax_r, s1_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
    if (en) begin
      acx_r   <= DW'(in_a_x) - DW'(in_c_x);
      acy_r   <= DW'(in_a_y) - DW'(in_c_y);
      cdx_r   <= DW'(in_d_x) - DW'(in_c_x);
      cdy_r   <= DW'(in_d_y) - DW'(in_c_y);
      abx_r   <= DW'(in_b_x) - DW'(in_a_x);
      aby_r   <= DW'(in_b_y) - DW'(in_a_y);
      s1_ax_r <= in_a_x;
      s1_ay_r <= in_a_y;
    end
  end

  // stage 2: products
  logic                 s2_v_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [DW-1:0] s2_abx_r, s2_aby_r;
  logic signed [CW-1:0] s2_ax_r, s2_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
    if (en) begin
      p0_r     <= PW'(acy_r) * PW'(cdx_r);
      p1_r     <= PW'(acx_r) * PW'(cdy_r);
      p2_r     <= PW'(acy_r) * PW'(abx_r);
      p3_r     <= PW'(acx_r) * PW'(aby_r);
      p4_r     <= PW'(abx_r) * PW'(cdy_r);
      p5_r     <= PW'(aby_r) * PW'(cdx_r);
      s2_abx_r <= abx_r;
      s2_aby_r <= aby_r;
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
    end
  end

  // stage 3: cross terms
  logic                 s3_v_r;
  logic signed [NW-1:0] num_r, numcd_r, den_r;
  logic signed [DW-1:0] s3_abx_r, s3_aby_r;
  logic signed [CW-1:0] s3_ax_r, s3_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
    if (en) begin
      num_r    <= NW'(p0_r) - NW'(p1_r);
      numcd_r  <= NW'(p2_r) - NW'(p3_r);
      den_r    <= NW'(p4_r) - NW'(p5_r);
      s3_abx_r <= s2_abx_r;
      s3_aby_r <= s2_aby_r;
      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
    end
  end

  // stage 4: magnitudes, signs and classification
  logic              inab, incd, den_zero;
  sic_pkg::kind_t    kind_nxt;
  logic [NW-1:0]     num_abs, den_abs;
  logic [DW-1:0]     abx_abs, aby_abs;

  always_comb begin
    den_zero = (den_r == '0);
    if (den_r > 0) begin
      inab = (num_r >= 0) && (num_r <= den_r);
      incd = (numcd_r >= 0) && (numcd_r <= den_r);
    end else begin
      inab = (num_r <= 0) && (num_r >= den_r);
      incd = (numcd_r <= 0) && (numcd_r >= den_r);
    end
    if (den_zero) begin
      kind_nxt = (num_r == '0) ? sic_pkg::KIND_COLLINEAR : sic_pkg::KIND_PARALLEL;
    end else if (inab && incd) begin
      kind_nxt = sic_pkg::KIND_SEG_CROSS;
    end else if (incd) begin
      kind_nxt = sic_pkg::KIND_A_BIS_B;
    end else if (inab) begin
      kind_nxt = sic_pkg::KIND_B_BIS_A;
    end else begin
      kind_nxt = sic_pkg::KIND_LINES;
    end
    num_abs = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
    den_abs = den_r[NW-1] ? NW'(-den_r) : NW'(den_r);
    abx_abs = s3_abx_r[DW-1] ? DW'(-s3_abx_r) : DW'(s3_abx_r);
    aby_abs = s3_aby_r[DW-1] ? DW'(-s3_aby_r) : DW'(s3_aby_r);
  end

  logic                 s4_v_r;
  sic_pkg::div_t        s4_r;
  logic [MW-1:0]        s4_num_r;
  logic [DW-1:0]        s4_mx_r, s4_my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
    if (en) begin
      s4_r.kind    <= kind_nxt;
      s4_r.dz      <= den_zero;
      s4_r.base_x  <= s3_ax_r;
      s4_r.base_y  <= s3_ay_r;
      s4_r.neg_x   <= num_r[NW-1] ^ s3_abx_r[DW-1] ^ den_r[NW-1];
      s4_r.neg_y   <= num_r[NW-1] ^ s3_aby_r[DW-1] ^ den_r[NW-1];
      s4_r.ovf_x   <= 1'b0;
      s4_r.ovf_y   <= 1'b0;
      s4_r.den_mag <= den_abs[MW-1:0];
      s4_num_r     <= num_abs[MW-1:0];
      s4_mx_r      <= abx_abs;
      s4_my_r      <= aby_abs;
    end
  end

  // stage 5: split multiply
  logic                   s5_v_r;
  sic_pkg::div_t          s5_r;
  logic [HW+DW-1:0]       plx_r, ply_r;
  logic [MW-HW+DW-1:0]    phx_r, phy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
    if (en) begin
      s5_r  <= s4_r;
      plx_r <= (HW+DW)'(s4_num_r[HW-1:0]) * (HW+DW)'(s4_mx_r);
      ply_r <= (HW+DW)'(s4_num_r[HW-1:0]) * (HW+DW)'(s4_my_r);
      phx_r <= (MW-HW+DW)'(s4_num_r[MW-1:HW]) * (MW-HW+DW)'(s4_mx_r);
      phy_r <= (MW-HW+DW)'(s4_num_r[MW-1:HW]) * (MW-HW+DW)'(s4_my_r);
    end
  end

  // stage 6: product sum
  logic          s6_v_r;
  sic_pkg::div_t s6_r;
  logic [RW-1:0] prx_r, pry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
    if (en) begin
      s6_r  <= s5_r;
      prx_r <= RW'({phx_r, {HW{1'b0}}}) + RW'(plx_r);
      pry_r <= RW'({phy_r, {HW{1'b0}}}) + RW'(ply_r);
    end
  end

  // stage 7 and division stages
  logic          dv_v_r  [QB+1];
  sic_pkg::div_t dv_r    [QB+1];
  logic [RW-1:0] rx_r    [QB+1];
  logic [RW-1:0] ry_r    [QB+1];
  logic [QB-1:0] qx_r    [QB+1];
  logic [QB-1:0] qy_r    [QB+1];
  logic [RW:0]   dlim;
  sic_pkg::div_t dv0_nxt;

  assign dlim = (RW+1)'({s6_r.den_mag, {QB{1'b0}}});

  always_comb begin
    dv0_nxt       = s6_r;
    dv0_nxt.ovf_x = ({1'b0, prx_r} >= dlim);
    dv0_nxt.ovf_y = ({1'b0, pry_r} >= dlim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= s6_v_r;
    end
    if (en) begin
      dv_r[0]       <= dv0_nxt;
      rx_r[0]       <= prx_r;
      ry_r[0]       <= pry_r;
      qx_r[0]       <= '0;
      qy_r[0]       <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BIT = QB - 1 - k;
    logic [RW-1:0] dsh;
    logic          gex, gey;
    assign dsh = RW'(dv_r[k].den_mag) << BIT;
    assign gex = (rx_r[k] >= dsh);
    assign gey = (ry_r[k] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      if (en) begin
        dv_r[k+1]      <= dv_r[k];
        rx_r[k+1]      <= gex ? rx_r[k] - dsh : rx_r[k];
        ry_r[k+1]      <= gey ? ry_r[k] - dsh : ry_r[k];
        qx_r[k+1]      <= qx_r[k] | (QB'(gex) << BIT);
        qy_r[k+1]      <= qy_r[k] | (QB'(gey) << BIT);
      end
    end
  end

  // final stage: apply sign, clamp
  sic_pkg::div_t    fin;
  logic signed [SW-1:0] sx, sy;
  logic signed [CW-1:0] cx_nxt, cy_nxt;
  logic                 satx, saty;

  assign fin = dv_r[QB];

  always_comb begin
    sx = fin.neg_x ? SW'(fin.base_x) - $signed(SW'(qx_r[QB]))
                   : SW'(fin.base_x) + $signed(SW'(qx_r[QB]));
    sy = fin.neg_y ? SW'(fin.base_y) - $signed(SW'(qy_r[QB]))
                   : SW'(fin.base_y) + $signed(SW'(qy_r[QB]));
    satx = 1'b1;
    saty = 1'b1;
    priority if (fin.ovf_x) begin
      cx_nxt = fin.neg_x ? sic_pkg::C_MIN : sic_pkg::C_MAX;
    end else if (sx > SW'(sic_pkg::C_MAX)) begin
      cx_nxt = sic_pkg::C_MAX;
    end else if (sx < SW'(sic_pkg::C_MIN)) begin
      cx_nxt = sic_pkg::C_MIN;
    end else begin
      cx_nxt = sx[CW-1:0];
      satx   = 1'b0;
    end
    priority if (fin.ovf_y) begin
      cy_nxt = fin.neg_y ? sic_pkg::C_MIN : sic_pkg::C_MAX;
    end else if (sy > SW'(sic_pkg::C_MAX)) begin
      cy_nxt = sic_pkg::C_MAX;
    end else if (sy < SW'(sic_pkg::C_MIN)) begin
      cy_nxt = sic_pkg::C_MIN;
    end else begin
      cy_nxt = sy[CW-1:0];
      saty   = 1'b0;
    end
  end

  logic                 out_valid_r;
  logic [2:0]           out_kind_r;
  logic signed [CW-1:0] out_cross_x_r, out_cross_y_r;
  logic                 out_pv_r, out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[QB];
    end
    if (en) begin
      out_kind_r    <= fin.kind;
      out_cross_x_r <= fin.dz ? '0 : cx_nxt;
      out_cross_y_r <= fin.dz ? '0 : cy_nxt;
      out_pv_r      <= !fin.dz;
      out_sat_r     <= !fin.dz && (satx || saty);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_cross_x         = out_cross_x_r;
  assign out_cross_y         = out_cross_y_r;
  assign out_point_valid     = out_pv_r;
  assign out_point_saturated = out_sat_r;

endmodule

>>> hdl/sic_checker.sv
// Port-level checker for segment_intersection_classify, bound to the top.
// Depends on sic_pkg.
module sic_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [2:0]                    out_kind,
  input logic signed [sic_pkg::CW-1:0] out_cross_x,
  input logic signed [sic_pkg::CW-1:0] out_cross_y,
  input logic                          out_point_valid,
  input logic                          out_point_saturated
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_cross_x))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |->
      out_cross_x == '0 && out_cross_y == '0 && !out_point_saturated &&
      (out_kind == sic_pkg::KIND_COLLINEAR || out_kind == sic_pkg::KIND_PARALLEL))
    else $error("no crossing point but point fields set");

  a_point_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_valid |->
      out_kind != sic_pkg::KIND_COLLINEAR && out_kind != sic_pkg::KIND_PARALLEL &&
      out_kind <= sic_pkg::KIND_LINES)
    else $error("crossing point with bad kind");

endmodule

bind segment_intersection_classify sic_checker u_sic_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_kind            (out_kind),
  .out_cross_x         (out_cross_x),
  .out_cross_y         (out_cross_y),
  .out_point_valid     (out_point_valid),
  .out_point_saturated (out_point_saturated)
);

>>> dv/tb_top.sv
// Self-checking testbench for segment_intersection_classify: random and directed
// segment pairs, a built-in predictor of kind, crossing point and flags.
// Depends on sic_pkg and the RTL top level.
module tb_top;

  localparam int CW      = sic_pkg::CW;
  localparam int QB      = sic_pkg::QB;
  localparam logic signed [CW-1:0] C_MAX = sic_pkg::C_MAX;
  localparam logic signed [CW-1:0] C_MIN = sic_pkg::C_MIN;
  localparam int LATENCY = 8 + QB;
  localparam int LIMIT   = 400000;

  typedef struct {
    logic [2:0]           kind;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic                 pv;
    logic                 ps;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] in_a_x, in_a_y, in_b_x, in_b_y, in_c_x, in_c_y, in_d_x, in_d_y;
  logic [2:0] out_kind;
  logic signed [CW-1:0] out_cross_x, out_cross_y;
  logic out_point_valid, out_point_saturated;

  answer_t answers_due[$];
  int unsigned fails = 0;
  int unsigned cycles = 0;
  int send_idle_pct;
  int stall_pct;

  segment_intersection_classify i_dut (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("** segment_intersection_classify: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // base + trunc(num*delta/den), clamped
  function automatic logic signed [CW-1:0] crossing(input logic signed [CW-1:0] base,
      input longint num, input longint delta, input longint den, inout logic sat);
    logic signed [191:0] q;
    logic signed [191:0] v;
    logic signed [191:0] n;
    n = 192'(num) * 192'(delta);
    q = n / 192'(den);
    v = 192'(base) + q;
    if (v > 192'(C_MAX)) begin
      sat = 1'b1;
      return C_MAX;
    end
    if (v < 192'(C_MIN)) begin
      sat = 1'b1;
      return C_MIN;
    end
    return v[CW-1:0];
  endfunction

  function automatic logic within_unit(input longint n, input longint den);
    if (den > 0) return n >= 0 && n <= den;
    return n <= 0 && n >= den;
  endfunction

  function automatic answer_t classify(input logic signed [CW-1:0] ax, ay, bx, by,
      cx, cy, dx, dy);
    answer_t r;
    longint acx, acy, cdx, cdy, abx, aby, num, numcd, den;
    logic sat, iab, icd;
    acx = longint'(ax) - cx;
    acy = longint'(ay) - cy;
    cdx = longint'(dx) - cx;
    cdy = longint'(dy) - cy;
    abx = longint'(bx) - ax;
    aby = longint'(by) - ay;
    num = acy * cdx - acx * cdy;
    numcd = acy * abx - acx * aby;
    den = abx * cdy - aby * cdx;
    r = '{default: '0};
    if (den == 0) begin
      r.kind = (num == 0) ? sic_pkg::KIND_COLLINEAR : sic_pkg::KIND_PARALLEL;
      return r;
    end
    sat = 1'b0;
    r.cx = crossing(ax, num, abx, den, sat);
    r.cy = crossing(ay, num, aby, den, sat);
    r.pv = 1'b1;
    r.ps = sat;
    iab = within_unit(num, den);
    icd = within_unit(numcd, den);
    if (iab && icd) r.kind = sic_pkg::KIND_SEG_CROSS;
    else if (icd) r.kind = sic_pkg::KIND_A_BIS_B;
    else if (iab) r.kind = sic_pkg::KIND_B_BIS_A;
    else r.kind = sic_pkg::KIND_LINES;
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        fails++;
        $display("%0t unexpected result kind %0d", $time, out_kind);
      end else begin
        e = answers_due.pop_front();
        if (e.kind !== out_kind || e.cx !== out_cross_x || e.cy !== out_cross_y
            || e.pv !== out_point_valid || e.ps !== out_point_saturated) begin
          fails++;
          $display("%0t mismatch exp kind %0d x %0d y %0d pv %b ps %b", $time, e.kind,
                   e.cx, e.cy, e.pv, e.ps);
          $display("%0t          got kind %0d x %0d y %0d pv %b ps %b", $time, out_kind,
                   out_cross_x, out_cross_y, out_point_valid, out_point_saturated);
        end
      end
    end
  end

  task automatic send_segments(input logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a_x <= ax; in_a_y <= ay; in_b_x <= bx; in_b_y <= by;
    in_c_x <= cx; in_c_y <= cy; in_d_x <= dx; in_d_y <= dy;
    answers_due.push_back(classify(ax, ay, bx, by, cx, cy, dx, dy));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($signed(CW'($urandom_range(4095))) - 2048);
      2: return $urandom_range(1) ? CW'(C_MAX - $urandom_range(3))
                                  : CW'(C_MIN + $urandom_range(3));
      default: return CW'($signed(CW'($urandom_range(262143))) - 131072);
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_segments(0, 0, 256, 256, 0, 256, 256, 0);
    send_segments(0, 0, 256, 0, 512, 0, 768, 0);
    send_segments(0, 0, 256, 0, 0, 256, 256, 256);
    send_segments(0, 0, 256, 0, 128, -256, 128, -64);
    send_segments(0, 0, 256, 0, 512, -256, 512, 256);
    send_segments(0, 0, 256, 0, 512, -256, 512, -64);
    send_segments(0, 0, 256, 256, 256, 256, 512, 0);
    send_segments(0, 0, 0, 0, 1, 2, 3, 4);
    send_segments(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
    send_segments(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_segments(C_MIN, 0, C_MAX, 1, C_MIN, 0, C_MAX, 0);
    send_segments(0, 0, C_MAX, 1, 0, 0, C_MAX, 0);
    send_segments(C_MAX, 0, C_MIN, 1, 0, C_MIN, 1, C_MAX);
    send_segments(C_MIN, C_MIN, CW'(C_MIN + 1), C_MIN, 0, 0, 1, 1);
    send_segments(C_MAX, C_MAX, CW'(C_MAX - 1), C_MAX, C_MIN, C_MIN, CW'(C_MIN + 1),
                  CW'(C_MIN + 1));
    send_segments(-1, -1, -1, 1, -2, 0, 2, 0);
    go_quiet();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) begin
      ax = rnd_coord(); ay = rnd_coord(); bx = rnd_coord(); by = rnd_coord();
      cx = rnd_coord(); cy = rnd_coord();
      case ($urandom_range(5))
        0: send_segments(ax, ay, bx, by, cx, cy, cx + (bx - ax), cy + (by - ay));
        1: send_segments(ax, ay, bx, by, ax, ay, bx, by);
        default: send_segments(ax, ay, bx, by, cx, cy, rnd_coord(), rnd_coord());
      endcase
    end
    go_quiet();
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_a_x, in_a_y, in_b_x, in_b_y, in_c_x, in_c_y, in_d_x, in_d_y} = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(140, 0, 0);
    test_random(130, 58, 0);
    test_random(130, 0, 58);
    test_random(130, 8, 8);
    stall_pct = 0;
    repeat (LATENCY + 10) @(posedge clk);
    if (fails == 0) $display("** segment_intersection_classify: PASSED **");
    else $display("** segment_intersection_classify: FAILED **");
    $finish;
  end
endmodule
